>>> rtl/core/xzhc_pkg.sv
// Shared types, constants and the preset level map for the xz header classifier.
package xzhc_pkg;

    typedef enum logic [2:0] {
        ST_DICT_FOUND   = 3'd0,
        ST_FALLBACK     = 3'd1,
        ST_TOO_SHORT    = 3'd2,
        ST_BAD_MAGIC    = 3'd3,
        ST_TOO_LONG     = 3'd4,
        ST_SECOND_STRM  = 3'd5,
        ST_CUSTOM_DICT  = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0] count;
        logic [3:0] first;
        logic [3:0] second;
    } t_levels;

    localparam logic [7:0] MAGIC [6] = '{8'hFD, 8'h37, 8'h7A, 8'h58, 8'h5A, 8'h00};
    localparam logic [39:0] MAGIC_HEAD    = 40'hFD_377A_585A;
    localparam logic [7:0]  FILTER_LZMA2  = 8'h21;
    localparam logic [7:0]  PROPS_LEN_ONE = 8'h01;
    localparam logic [7:0]  DICT_NONE     = 8'hFF;
    localparam logic [7:0]  VLI_CONT      = 8'h80;
    localparam logic [7:0]  FLT_CNT_MASK  = 8'h03;
    localparam logic [7:0]  FLG_CSIZE     = 8'h40;
    localparam logic [7:0]  FLG_USIZE     = 8'h80;
    localparam logic [3:0]  VLI_MAX       = 4'd9;
    localparam logic [10:0] HDR_BASE      = 11'd16;  // 12 + one size unit of 4

    function automatic t_levels map_levels(input logic [7:0] d);
        t_levels l;
        l = '{count: 2'd0, first: 4'd0, second: 4'd0};
        case (d)
            8'h0C: l = '{count: 2'd1, first: 4'd0, second: 4'd0};
            8'h10: l = '{count: 2'd1, first: 4'd1, second: 4'd0};
            8'h12: l = '{count: 2'd1, first: 4'd2, second: 4'd0};
            8'h14: l = '{count: 2'd2, first: 4'd3, second: 4'd4};
            8'h16: l = '{count: 2'd2, first: 4'd5, second: 4'd6};
            8'h18: l = '{count: 2'd1, first: 4'd7, second: 4'd0};
            8'h1A: l = '{count: 2'd1, first: 4'd8, second: 4'd0};
            8'h1C: l = '{count: 2'd1, first: 4'd9, second: 4'd0};
            default: l = '{count: 2'd0, first: 4'd0, second: 4'd0};
        endcase
        return l;
    endfunction

endpackage

>>> rtl/core/xz_stream_header_classifier.sv
// Top level: byte-stream xz file classifier with input and result registers.
//
// Usage:
//   Slave channel carries one file byte per item in i_s_tdata[7:0]; i_s_tlast
//   marks the final byte of a file. Each file yields exactly one result item
//   on the master channel, issued for its last byte; all parse state then
//   returns to its reset values so the next byte starts a new file.
//   Throughput: one byte per cycle when not stalled, set by the single-pass state
//   update that runs between the input register and the result register.
//   Result path: the last byte is held in the input register, and its result
//   is then registered in the result register.
//   Stall: a waiting result does not block bytes that produce no result;
//   only a last byte waits in the input register while the result register
//   is still full and not taken, and then o_s_tready drops.
//   Reset (i_rst_n low, synchronous): both registers empty, byte counter
//   zero, window clear, magic assumed good, parser waiting for the size byte.
//   The byte counter saturates at 2**LENGTH_BITS (status too long).
module xz_stream_header_classifier #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [2:0] status, [10:3] dict_value, [12:11] level_count,
    // [16:13] first_level, [20:17] second_level, [23:21] zero
    output logic [23:0] o_m_tdata
);
    import xzhc_pkg::*;

    localparam int PW = LENGTH_BITS + 1;   // counter with saturation bit
    localparam int CW = LENGTH_BITS + 2;   // room for small offsets

    typedef enum logic [2:0] {
        PH_SIZE, PH_FLAGS, PH_CSIZE, PH_USIZE, PH_FID, PH_PSIZE, PH_DICT, PH_DONE
    } t_phase;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // file state
    logic [PW-1:0] r_pos,      n_pos;
    logic [39:0]   r_win,      n_win;
    logic          r_magic_ok, n_magic_ok;
    logic          r_extra,    n_extra;
    t_phase        r_phase,    n_phase;
    logic [10:0]   r_hdr_end,  n_hdr_end;
    logic [7:0]    r_flags,    n_flags;
    logic [3:0]    r_vli_cnt,  n_vli_cnt;
    logic [7:0]    r_dict,     n_dict;
    logic          r_failed,   n_failed;

    // result register
    logic       r_out_valid;
    t_status    r_status,  n_status;
    logic [7:0] r_out_dict, n_out_dict;
    t_levels    r_levels,  n_levels;

    logic       advance;
    logic [7:0] v;
    logic [3:0] vli_inc;
    t_levels    lv;

    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign v          = r_in_byte;
    assign vli_inc    = r_vli_cnt + 4'd1;
    assign lv         = map_levels(r_dict);

    always_comb begin
        n_pos      = r_pos;
        n_win      = {r_win[31:0], v};
        n_magic_ok = r_magic_ok;
        n_extra    = r_extra;
        n_phase    = r_phase;
        n_hdr_end  = r_hdr_end;
        n_flags    = r_flags;
        n_vli_cnt  = r_vli_cnt;
        n_dict     = r_dict;
        n_failed   = r_failed;
        n_status   = ST_FALLBACK;
        n_out_dict = DICT_NONE;
        n_levels   = '{count: 2'd0, first: 4'd0, second: 4'd0};

        if (r_pos < PW'(6) && v != MAGIC[r_pos[2:0]]) begin
            n_magic_ok = 1'b0;
        end
        if (r_pos >= PW'(11) && v == 8'h00 && r_win == MAGIC_HEAD) begin
            n_extra = 1'b1;
        end

        if (!r_failed && r_phase != PH_DONE) begin
            case (r_phase)
                PH_SIZE: begin
                    if (r_pos == PW'(12)) begin
                        if (v == 8'h00) begin
                            n_failed = 1'b1;
                        end else begin
                            n_hdr_end = {1'b0, v, 2'b00} + HDR_BASE;
                            n_phase   = PH_FLAGS;
                        end
                    end
                end
                PH_FLAGS: begin
                    n_flags = v;
                    if ((v & FLT_CNT_MASK) != 8'h00) begin
                        n_failed = 1'b1;
                    end else begin
                        n_vli_cnt = 4'd0;
                        if ((v & FLG_CSIZE) != 8'h00)      n_phase = PH_CSIZE;
                        else if ((v & FLG_USIZE) != 8'h00) n_phase = PH_USIZE;
                        else                               n_phase = PH_FID;
                    end
                end
                PH_CSIZE, PH_USIZE: begin
                    if (r_pos >= PW'(r_hdr_end)) begin
                        n_failed = 1'b1;
                    end else if ((v & VLI_CONT) == 8'h00) begin
                        n_vli_cnt = 4'd0;
                        if (r_phase == PH_CSIZE && (r_flags & FLG_USIZE) != 8'h00) begin
                            n_phase = PH_USIZE;
                        end else begin
                            n_phase = PH_FID;
                        end
                    end else begin
                        n_vli_cnt = vli_inc;
                        if (vli_inc >= VLI_MAX) n_failed = 1'b1;
                    end
                end
                PH_FID: begin
                    if (CW'(r_pos) + CW'(3) > CW'(r_hdr_end) || v != FILTER_LZMA2) begin
                        n_failed = 1'b1;
                    end else begin
                        n_phase = PH_PSIZE;
                    end
                end
                PH_PSIZE: begin
                    if (v != PROPS_LEN_ONE) n_failed = 1'b1;
                    else                    n_phase  = PH_DICT;
                end
                PH_DICT: begin
                    n_dict  = v;
                    n_phase = PH_DONE;
                end
                default: n_failed = 1'b1;
            endcase
        end

        if (!r_pos[PW-1]) n_pos = r_pos + PW'(1);

        // classification, using the state after this byte
        if (n_pos < PW'(12))                 n_status = ST_TOO_SHORT;
        else if (!n_magic_ok)                n_status = ST_BAD_MAGIC;
        else if (n_pos[PW-1])                n_status = ST_TOO_LONG;
        else if (n_extra)                    n_status = ST_SECOND_STRM;
        else if (n_failed || n_phase != PH_DONE ||
                 CW'(n_pos) < CW'(n_hdr_end) + CW'(4)) n_status = ST_FALLBACK;
        else begin
            // phase only reaches done on a byte before this one, so r_dict holds it
            n_out_dict = r_dict;
            if (lv.count != 2'd0) begin
                n_status = ST_DICT_FOUND;
                n_levels = lv;
            end else begin
                n_status = ST_CUSTOM_DICT;
            end
        end

        // end of file: back to reset for the next one
        if (r_in_last) begin
            n_pos      = '0;
            n_win      = '0;
            n_magic_ok = 1'b1;
            n_extra    = 1'b0;
            n_phase    = PH_SIZE;
            n_hdr_end  = '0;
            n_flags    = '0;
            n_vli_cnt  = '0;
            n_dict     = DICT_NONE;
            n_failed   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_win       <= '0;
            r_magic_ok  <= 1'b1;
            r_extra     <= 1'b0;
            r_phase     <= PH_SIZE;
            r_hdr_end   <= '0;
            r_flags     <= '0;
            r_vli_cnt   <= '0;
            r_dict      <= DICT_NONE;
            r_failed    <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_pos      <= n_pos;
                r_win      <= n_win;
                r_magic_ok <= n_magic_ok;
                r_extra    <= n_extra;
                r_phase    <= n_phase;
                r_hdr_end  <= n_hdr_end;
                r_flags    <= n_flags;
                r_vli_cnt  <= n_vli_cnt;
                r_dict     <= n_dict;
                r_failed   <= n_failed;
            end
            if (advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (advance && r_in_last) begin
            r_status   <= n_status;
            r_out_dict <= n_out_dict;
            r_levels   <= n_levels;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_levels.second, r_levels.first, r_levels.count,
                         r_out_dict, r_status};

    // checks
    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos[PW-1] |-> (r_pos[PW-2:0] == '0))
        else $error("byte counter passed saturation");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_pos == '0 && r_phase == PH_SIZE && !r_failed))
        else $error("file state not cleared after last byte");

    a_levels_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_levels.count != 2'd0) |-> (r_status == ST_DICT_FOUND))
        else $error("levels reported without dict found");

    a_dict_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_status != ST_DICT_FOUND && r_status != ST_CUSTOM_DICT)
            |-> (r_out_dict == DICT_NONE))
        else $error("dict byte reported on failed parse");

    a_stall_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_in_last && r_out_valid))
        else $error("input stalled without a pending result");

endmodule
